FILE: rtl/core/affinity_context_scheduler_assert.svh
// Assertion macros for the affinity context scheduler checker.
// Used by affinity_context_scheduler_checker.sv only.
`ifndef AFFINITY_CONTEXT_SCHEDULER_ASSERT_SVH
`define AFFINITY_CONTEXT_SCHEDULER_ASSERT_SVH
// Implication checked every cycle, disabled during reset.
`define ACS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ACS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/acs_pkg.sv
// Package for the affinity context scheduler: sizes, codes, control structs.
// No dependencies.
`default_nettype none
package acs_pkg;
    localparam int CORES = 2;
    localparam int THREADS_PER_CORE = 2;
    localparam int NODES = CORES * THREADS_PER_CORE;
    localparam int NW = 2;
    localparam int MAX_CTX = 16;
    localparam int CW = 4;
    localparam int TW = 48;
    localparam logic [31:0] QUANTUM_RESET = 32'd100000;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // Datapath operation codes issued by the controller
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,  // apply write/drain, bump cycle count on a tick
        OP_CHECK  = 4'd2,  // decide whether a pass runs
        OP_MAP    = 4'd3,  // map entry at scan index
        OP_EVICT  = 4'd4,  // node eviction decisions (uses rival flag)
        OP_RIVAL  = 4'd5,  // scan entry for rival
        OP_UNMAP  = 4'd6,  // unmap scan entry if stale
        OP_PICK   = 4'd7,  // allocation candidate scan
        OP_ALLOC  = 4'd8,  // commit allocation
        OP_OLDEST = 4'd9,  // oldest alloc time fold, one node
        OP_EMIT   = 4'd10  // present one result
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [CW-1:0]   idx;
        logic [NW-1:0]   node;
        logic            first;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic run;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/core/acs_ctrl.sv
// Controller state machine for the affinity context scheduler.
// Depends on acs_pkg.
`default_nettype none
module acs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    output logic             o_busy,
    output acs_pkg::t_cmd    o_cmd,
    input  acs_pkg::t_stat   i_stat
);
    import acs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_LOAD   = 11'b00000000010,
        S_CHECK  = 11'b00000000100,
        S_MAP    = 11'b00000001000,
        S_RIVAL  = 11'b00000010000,
        S_EVICT  = 11'b00000100000,
        S_UNMAP  = 11'b00001000000,
        S_PICK   = 11'b00010000000,
        S_ALLOC  = 11'b00100000000,
        S_OLDEST = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_idx, n_idx;
    logic [NW-1:0]   r_node, n_node;
    logic            last_idx, last_node;

    assign last_idx  = (r_idx == CW'(MAX_CTX - 1));
    assign last_node = (r_node == NW'(NODES - 1));

    // Next state and scan counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_node  = r_node;
        o_cmd   = '{op: OP_NONE, idx: r_idx, node: r_node, first: (r_idx == '0)};
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state = i_stat.is_tick ? S_CHECK : S_EMIT;
                n_idx = '0;
                n_node = '0;
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state = i_stat.run ? S_MAP : S_EMIT;
            end
            S_MAP: begin
                o_cmd.op = OP_MAP;
                n_idx = r_idx + 1'b1;
                if (last_idx) n_state = S_RIVAL;
            end
            S_RIVAL: begin
                o_cmd.op = OP_RIVAL;
                n_idx = r_idx + 1'b1;
                if (last_idx) n_state = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.op = OP_EVICT;
                n_state = S_UNMAP;
            end
            S_UNMAP: begin
                o_cmd.op = OP_UNMAP;
                n_idx = r_idx + 1'b1;
                if (last_idx) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.op = OP_PICK;
                n_idx = r_idx + 1'b1;
                if (last_idx) n_state = S_ALLOC;
            end
            S_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                n_node = r_node + 1'b1;
                n_state = last_node ? S_OLDEST : S_RIVAL;
            end
            S_OLDEST: begin
                o_cmd.op = OP_OLDEST;
                o_cmd.first = (r_node == '0);
                n_node = r_node + 1'b1;
                if (last_node) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_node = r_node + 1'b1;
                if (last_node) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_node  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_node  <= n_node;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

FILE: rtl/core/acs_dp.sv
// Datapath for the affinity context scheduler: context table, node state,
// time registers, result register. Depends on acs_pkg.
`default_nettype none
module acs_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_busy,
    input  acs_pkg::t_cmd       i_cmd,
    output acs_pkg::t_stat      o_stat,
    input  wire                 i_cfg_we,
    input  wire  [31:0]         i_cfg_wdata,
    input  wire  [1:0]          i_req_type,
    input  wire  [3:0]          i_ctx_id,
    input  wire                 i_ctx_running,
    input  wire                 i_ctx_finished,
    input  wire  [3:0]          i_ctx_affinity,
    input  wire  [1:0]          i_node_id,
    input  wire  [3:0]          i_pipeline_empty_mask,
    output logic                o_result_valid,
    output logic [1:0]          o_out_node,
    output logic                o_alloc_valid,
    output logic [3:0]          o_alloc_ctx,
    output logic                o_evict_waiting,
    output logic                o_pass_ran,
    output logic                o_last
);
    import acs_pkg::*;

    logic [31:0]          r_quantum;
    logic [1:0]           r_req;
    logic [CW-1:0]        r_id;
    logic                 r_run_in, r_fin_in;
    logic [3:0]           r_aff_in;
    logic [NW-1:0]        r_nid;
    logic [3:0]           r_empty;
    logic                 r_ran;

    logic [MAX_CTX-1:0]   r_valid, r_running, r_finished, r_mapped;
    logic [3:0]           r_aff  [MAX_CTX];
    logic [NW-1:0]        r_enode[MAX_CTX];
    logic [TW-1:0]        r_atime[MAX_CTX];
    logic [TW-1:0]        r_etime[MAX_CTX];
    logic [NODES-1:0]     r_nbusy, r_nflag;
    logic [CW-1:0]        r_holder[NODES];
    logic [4:0]           r_mcount[NODES];
    logic [TW-1:0]        r_cycle, r_oldest;
    logic                 r_pending;

    // scan scratch
    logic                 r_rival, r_found;
    logic [CW-1:0]        r_pick;
    logic [TW-1:0]        r_oacc;

    logic [CW-1:0]        idx, h;
    logic [NW-1:0]        nd;
    logic                 aff_hn, empty_n;
    logic [TW:0]          q_lim_h, q_lim_o;
    logic                 exp_h, exp_o;
    logic [NW-1:0]        best;
    logic                 best_ok;
    logic                 on_node;

    assign idx = i_cmd.idx;
    assign nd  = i_cmd.node;
    assign h   = r_holder[nd];
    assign aff_hn  = r_aff[h][nd];
    assign empty_n = r_empty[nd];
    assign q_lim_h = {1'b0, r_atime[h]} + {17'd0, r_quantum};
    assign q_lim_o = {1'b0, r_oldest} + {17'd0, r_quantum};
    assign exp_h = ({1'b0, r_cycle} >= q_lim_h);
    assign exp_o = ({1'b0, r_cycle} >= q_lim_o);
    assign on_node = r_mapped[idx] && (r_enode[idx] == nd);

    // least-loaded affine node for the scan entry
    always_comb begin
        best = '0;
        best_ok = 1'b0;
        for (int n = 0; n < NODES; n++) begin
            if (n < 4 && r_aff[idx][n]) begin
                if (!best_ok || r_mcount[n] < r_mcount[best]) begin
                    best = NW'(n);
                    best_ok = 1'b1;
                end
            end
        end
    end

    assign o_stat.is_tick = (r_req == REQ_TICK);
    assign o_stat.run     = exp_o || r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
            r_valid <= '0; r_running <= '0; r_finished <= '0; r_mapped <= '0;
            r_nbusy <= '0; r_nflag <= '0;
            r_cycle <= '0; r_oldest <= '0; r_pending <= 1'b0;
            r_ran <= 1'b0;
            o_result_valid <= 1'b0; o_out_node <= '0; o_alloc_valid <= 1'b0;
            o_alloc_ctx <= '0; o_evict_waiting <= 1'b0; o_pass_ran <= 1'b0;
            o_last <= 1'b0;
            for (int i = 0; i < MAX_CTX; i++) begin
                r_atime[i] <= '0;
                r_etime[i] <= '0;
            end
            for (int n = 0; n < NODES; n++) begin
                r_holder[n] <= '0;
                r_mcount[n] <= '0;
            end
        end else begin
            o_result_valid <= (i_cmd.op == OP_EMIT);
            if (i_cfg_we) r_quantum <= i_cfg_wdata;
            // capture transaction
            if (i_start && !i_busy) begin
                r_req <= i_req_type; r_id <= i_ctx_id; r_run_in <= i_ctx_running;
                r_fin_in <= i_ctx_finished; r_aff_in <= i_ctx_affinity;
                r_nid <= i_node_id; r_empty <= i_pipeline_empty_mask;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_ran <= 1'b0;
                    if (r_req == REQ_TICK) begin
                        r_cycle <= r_cycle + 1'b1;
                    end else if (r_req == REQ_WRITE) begin
                        r_valid[r_id] <= 1'b1;
                        r_running[r_id] <= r_run_in;
                        r_finished[r_id] <= r_fin_in;
                        r_aff[r_id] <= r_aff_in;
                        r_pending <= 1'b1;
                    end else if (r_req == REQ_DRAIN) begin
                        if (r_nbusy[r_nid] && r_nflag[r_nid]) begin
                            r_etime[r_holder[r_nid]] <= r_cycle;
                            r_nbusy[r_nid] <= 1'b0;
                            r_nflag[r_nid] <= 1'b0;
                        end
                    end
                end
                OP_CHECK: begin
                    if (o_stat.run) begin
                        r_pending <= 1'b0;
                        r_ran <= 1'b1;
                    end
                end
                OP_MAP: begin
                    if (r_valid[idx] && r_running[idx] && !r_mapped[idx] && best_ok) begin
                        r_mapped[idx] <= 1'b1;
                        r_enode[idx] <= best;
                        r_mcount[best] <= r_mcount[best] + 1'b1;
                    end
                end
                OP_RIVAL: begin
                    if (idx != h && on_node && r_running[idx]) r_rival <= 1'b1;
                    else if (i_cmd.first) r_rival <= 1'b0;
                end
                OP_EVICT: begin
                    if (r_nbusy[nd] && !r_nflag[nd]) begin
                        if (!r_running[h] || !aff_hn || (exp_h && r_rival)) begin
                            if (empty_n) begin
                                r_etime[h] <= r_cycle;
                                r_nbusy[nd] <= 1'b0;
                                r_nflag[nd] <= 1'b0;
                            end else begin
                                r_nflag[nd] <= 1'b1;
                            end
                        end else if (exp_h) begin
                            r_atime[h] <= r_cycle;
                        end
                    end
                end
                OP_UNMAP: begin
                    if (on_node && !(r_nbusy[nd] && h == idx)) begin
                        if (!r_aff[idx][nd] || r_finished[idx]) begin
                            r_mapped[idx] <= 1'b0;
                            if (r_mcount[nd] != '0) r_mcount[nd] <= r_mcount[nd] - 1'b1;
                            if (r_finished[idx]) r_valid[idx] <= 1'b0;
                        end
                    end
                end
                OP_PICK: begin
                    if (on_node && r_aff[idx][nd] && r_running[idx] &&
                        (!(r_found && !i_cmd.first) || r_etime[r_pick] > r_etime[idx])) begin
                        r_found <= 1'b1;
                        r_pick <= idx;
                    end else if (i_cmd.first) begin
                        r_found <= 1'b0;
                    end
                end
                OP_ALLOC: begin
                    if (!r_nbusy[nd] && r_found) begin
                        r_atime[r_pick] <= r_cycle;
                        r_nbusy[nd] <= 1'b1;
                        r_holder[nd] <= r_pick;
                        r_nflag[nd] <= 1'b0;
                    end
                end
                OP_OLDEST: begin
                    if (r_nbusy[nd] && !r_nflag[nd] &&
                        r_atime[h] < (i_cmd.first ? r_cycle : r_oacc)) begin
                        r_oacc <= r_atime[h];
                        if (nd == NW'(NODES - 1)) r_oldest <= r_atime[h];
                    end else begin
                        r_oacc <= i_cmd.first ? r_cycle : r_oacc;
                        if (nd == NW'(NODES - 1)) r_oldest <= i_cmd.first ? r_cycle : r_oacc;
                    end
                end
                OP_EMIT: begin
                    o_out_node <= nd;
                    o_alloc_valid <= r_nbusy[nd];
                    o_alloc_ctx <= r_nbusy[nd] ? h : '0;
                    o_evict_waiting <= r_nbusy[nd] && r_nflag[nd];
                    o_pass_ran <= r_ran;
                    o_last <= (nd == NW'(NODES - 1));
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/affinity_context_scheduler.sv
// A tick that runs a pass makes one table scan to map, then for each node three
// 16-entry scans plus two steps, then an oldest-time step and a result per node.
// Writes and drains load, then emit; a tick with no pass loads, checks, emits.
// One transaction at a time; results are registered, one per cycle, unstalled.
// Reset is synchronous, active low; quantum resets to 100000.
// Top level: controller and datapath. Depends on acs_pkg, acs_ctrl, acs_dp.
`default_nettype none
module affinity_context_scheduler (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          start,
    output logic         busy,
    input  wire          i_cfg_we,
    input  wire  [31:0]  i_cfg_wdata,
    input  wire  [1:0]   i_req_type,
    input  wire  [3:0]   i_ctx_id,
    input  wire          i_ctx_running,
    input  wire          i_ctx_finished,
    input  wire  [3:0]   i_ctx_affinity,
    input  wire  [1:0]   i_node_id,
    input  wire  [3:0]   i_pipeline_empty_mask,
    output logic         o_result_valid,
    output logic [1:0]   o_out_node,
    output logic         o_alloc_valid,
    output logic [3:0]   o_alloc_ctx,
    output logic         o_evict_waiting,
    output logic         o_pass_ran,
    output logic         o_last
);
    import acs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    acs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_cmd(cmd), .i_stat(stat)
    );

    acs_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req_type(i_req_type), .i_ctx_id(i_ctx_id),
        .i_ctx_running(i_ctx_running), .i_ctx_finished(i_ctx_finished),
        .i_ctx_affinity(i_ctx_affinity), .i_node_id(i_node_id),
        .i_pipeline_empty_mask(i_pipeline_empty_mask),
        .o_result_valid(o_result_valid), .o_out_node(o_out_node),
        .o_alloc_valid(o_alloc_valid), .o_alloc_ctx(o_alloc_ctx),
        .o_evict_waiting(o_evict_waiting), .o_pass_ran(o_pass_ran),
        .o_last(o_last)
    );
endmodule
`default_nettype wire

FILE: rtl/core/affinity_context_scheduler_checker.sv
// Port-level checker for the affinity context scheduler, with its bind.
// Depends on affinity_context_scheduler_assert.svh.
`default_nettype none
module affinity_context_scheduler_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_result_valid,
    input wire [1:0]  o_out_node,
    input wire        o_alloc_valid,
    input wire [3:0]  o_alloc_ctx,
    input wire        o_evict_waiting,
    input wire        o_last
);
    `include "affinity_context_scheduler_assert.svh"

    // an accepted transaction makes the block busy
    `ACS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // last marks the highest node only
    `ACS_ASSERT_IMP(a_last_node, i_clk, i_rst_n, o_result_valid, o_last == (o_out_node == 2'd3))
    // an idle node reports no context and no pending eviction
    `ACS_ASSERT_IMP(a_idle_node, i_clk, i_rst_n, o_result_valid && !o_alloc_valid,
        o_alloc_ctx == 4'd0 && !o_evict_waiting)
    // results follow in node order
    `ACS_ASSERT_NXT(a_node_order, i_clk, i_rst_n, o_result_valid && !o_last,
        o_result_valid && o_out_node == $past(o_out_node) + 2'd1)
endmodule

bind affinity_context_scheduler affinity_context_scheduler_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_result_valid(o_result_valid), .o_out_node(o_out_node),
    .o_alloc_valid(o_alloc_valid), .o_alloc_ctx(o_alloc_ctx),
    .o_evict_waiting(o_evict_waiting), .o_last(o_last)
);
`default_nettype wire
